@@ hdl/sbckx_pkg.sv @@
package sbckx_pkg;

    localparam int SCREEN_WIDTH_DEF  = 320;
    localparam int SCREEN_HEIGHT_DEF = 200;

    localparam logic [31:0] BG_PIXEL = 32'h0000_00FF;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X     = 2'd0,
        CFG_ORIGIN_Y     = 2'd1,
        CFG_SPRITE_WIDTH = 2'd2,
        CFG_BLEND_ENABLE = 2'd3
    } t_cfg_idx;

    localparam logic [8:0] SPRITE_WIDTH_RST = 9'd16;

endpackage

@@ hdl/sprite_blit_color_key_xor_core.sv @@
// Sprite blitter into an internal SCREEN_WIDTH x SCREEN_HEIGHT frame buffer of 32-bit pixels.
// One sprite pixel is taken per cycle while the output side accepts results, and each item passes
// through the address stage, the buffer read stage and the output register. The rate is set by
// the single read-modify-write of the frame buffer memory per item; a write that lands on the
// entry being read in the same cycle is forwarded. After reset the buffer is filled with the
// background value 0x000000FF by a clearing pass over all SCREEN_WIDTH*SCREEN_HEIGHT entries (64000
// at the default size), one entry per cycle through the memory's write port; no item is
// accepted until it ends, while configuration writes are taken as usual.
module sprite_blit_color_key_xor_core #(
    parameter int SCREEN_WIDTH  = sbckx_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = sbckx_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration
    input  logic                             i_cfg_we,
    input  logic [sbckx_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sbckx_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input items
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [31:0]                      i_src_pixel,
    input  logic                             i_last,
    // result items
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_written,
    output logic [15:0]                      o_fb_address,
    output logic [31:0]                      o_stored_value,
    output logic                             o_done_res
);
    import sbckx_pkg::*;

    localparam int FB_DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int AW       = $clog2(FB_DEPTH);
    localparam int CW       = $clog2(SCREEN_WIDTH);
    localparam int RW       = $clog2(SCREEN_HEIGHT);

    localparam logic [11:0]   SW_LIM   = 12'(SCREEN_WIDTH);
    localparam logic [10:0]   SH_LIM   = 11'(SCREEN_HEIGHT);
    localparam logic [AW-1:0] SW_MUL   = AW'(SCREEN_WIDTH);
    localparam logic [AW-1:0] CLR_LAST = AW'(FB_DEPTH - 1);

    // configuration registers
    logic [10:0] r_origin_x;
    logic [8:0]  r_origin_y;
    logic [8:0]  r_sprite_width;
    logic        r_blend;

    // sprite position counters
    logic [8:0]  r_col, n_col;
    logic [8:0]  r_row, n_row;

    // clearing pass
    logic          r_clr_active;
    logic [AW-1:0] r_clr_addr;

    // address stage
    logic          r1_valid;
    logic          r1_wr;
    logic [31:0]   r1_pix;
    logic          r1_last;
    logic [CW-1:0] r1_col;
    logic [RW-1:0] r1_row;

    // buffer read stage
    logic          r2_valid;
    logic          r2_wr;
    logic [31:0]   r2_pix;
    logic          r2_last;
    logic [AW-1:0] r2_addr;
    logic [31:0]   r_rdata;
    logic          r_fwd_hit;
    logic [31:0]   r_fwd_data;

    // output register
    logic          r_out_valid;
    logic          r_out_written;
    logic [AW-1:0] r_out_addr;
    logic [31:0]   r_out_value;
    logic          r_out_last;

    logic [31:0]   r_fb [FB_DEPTH];

    logic              w_adv;
    logic              w_acc;
    logic signed [11:0] w0_x;
    logic signed [10:0] w0_y;
    logic              w0_inside;
    logic [9:0]        w0_nc;
    logic [AW-1:0]     w1_addr;
    logic              w1_rd;
    logic [31:0]       w2_old;
    logic [31:0]       w2_new;
    logic              w2_we;
    logic              w_mem_we;
    logic [AW-1:0]     w_mem_waddr;
    logic [31:0]       w_mem_wdata;
    logic [AW+15:0]    w_addr_ext;

    // the whole pipeline moves together whenever the output register can take an item
    assign w_adv      = !r_out_valid || i_out_ready;
    assign o_in_ready = w_adv && !r_clr_active;
    assign w_acc      = i_in_valid && o_in_ready;

    // destination and clipping
    assign w0_x = $signed({r_origin_x[10], r_origin_x}) + $signed({3'b000, r_col});
    assign w0_y = $signed({{2{r_origin_y[8]}}, r_origin_y}) + $signed({2'b00, r_row});
    assign w0_inside = (i_src_pixel[7:0] != 8'h00)
                    && !w0_x[11] && (12'(w0_x) < SW_LIM)
                    && !w0_y[10] && (11'(w0_y) < SH_LIM);

    always_comb begin
        w0_nc = {1'b0, r_col} + 10'd1;
        n_col = r_col;
        n_row = r_row;
        if (w_acc) begin
            if (i_last) begin
                n_col = '0;
                n_row = '0;
            end else if (w0_nc >= {1'b0, r_sprite_width}) begin
                // a width of zero ends every row, like a width of one
                n_col = '0;
                n_row = r_row + 9'd1;
            end else begin
                n_col = w0_nc[8:0];
            end
        end
    end

    assign w1_addr = AW'(r1_row) * SW_MUL + AW'(r1_col);
    assign w1_rd   = w_adv && r1_valid && r1_wr;

    assign w2_old = r_fwd_hit ? r_fwd_data : r_rdata;
    assign w2_new = (r_blend && (w2_old != BG_PIXEL)) ? (r2_pix ^ w2_old) : r2_pix;
    assign w2_we  = w_adv && r2_valid && r2_wr;

    always_comb begin
        if (r_clr_active) begin
            w_mem_we    = 1'b1;
            w_mem_waddr = r_clr_addr;
            w_mem_wdata = BG_PIXEL;
        end else begin
            w_mem_we    = w2_we;
            w_mem_waddr = r2_addr;
            w_mem_wdata = w2_new;
        end
    end

    // frame buffer
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_fb[w_mem_waddr] <= w_mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w1_rd) begin
            r_rdata <= r_fb[w1_addr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x     <= '0;
            r_origin_y     <= '0;
            r_sprite_width <= SPRITE_WIDTH_RST;
            r_blend        <= 1'b0;
            r_col          <= '0;
            r_row          <= '0;
            r_clr_active   <= 1'b1;
            r_clr_addr     <= '0;
            r1_valid       <= 1'b0;
            r2_valid       <= 1'b0;
            r_fwd_hit      <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_ORIGIN_X:     r_origin_x     <= i_cfg_data[10:0];
                    CFG_ORIGIN_Y:     r_origin_y     <= i_cfg_data[8:0];
                    CFG_SPRITE_WIDTH: r_sprite_width <= i_cfg_data[8:0];
                    CFG_BLEND_ENABLE: r_blend        <= i_cfg_data[0];
                    default:          r_blend        <= r_blend;
                endcase
            end
            r_col <= n_col;
            r_row <= n_row;
            if (r_clr_active) begin
                r_clr_addr <= r_clr_addr + AW'(1);
                if (r_clr_addr == CLR_LAST) begin
                    r_clr_active <= 1'b0;
                end
            end
            if (w_adv) begin
                r1_valid    <= w_acc;
                r2_valid    <= r1_valid;
                r_out_valid <= r2_valid;
                // a write landing on the entry read at the same edge is forwarded
                r_fwd_hit   <= w1_rd && w2_we && (r2_addr == w1_addr);
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_wr      <= w0_inside;
            r1_pix     <= i_src_pixel;
            r1_last    <= i_last;
            r1_col     <= w0_x[CW-1:0];
            r1_row     <= w0_y[RW-1:0];
            r2_wr      <= r1_wr;
            r2_pix     <= r1_pix;
            r2_last    <= r1_last;
            r2_addr    <= w1_addr;
            r_fwd_data <= w2_new;
            r_out_written <= r2_wr;
            r_out_addr    <= r2_wr ? r2_addr : '0;
            r_out_value   <= r2_wr ? w2_new : '0;
            r_out_last    <= r2_last;
        end
    end

    assign w_addr_ext     = {16'h0000, r_out_addr};
    assign o_out_valid    = r_out_valid;
    assign o_written      = r_out_written;
    assign o_fb_address   = w_addr_ext[15:0];
    assign o_stored_value = r_out_value;
    assign o_done_res     = r_out_last;

    a_no_pixel_write_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_active |-> !(r2_valid && r2_wr) && !r1_valid)
        else $error("pixel write pending during clearing pass");

    a_fwd_only_for_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd_hit |-> (r2_valid && r2_wr))
        else $error("forward flag set without a pending write");

    a_dropped_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_written) |-> (r_out_addr == '0) && (r_out_value == '0))
        else $error("dropped pixel reports nonzero address or value");

    a_addr_in_buffer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_written) |-> (r_out_addr <= CLR_LAST))
        else $error("write address beyond frame buffer");

endmodule

@@ bench/sprite_blit_color_key_xor_core_test.sv @@
module sprite_blit_color_key_xor_core_test;

    import sbckx_pkg::*;

    localparam int SCR_W = SCREEN_WIDTH_DEF;
    localparam int SCR_H = SCREEN_HEIGHT_DEF;
    localparam int FB_DEPTH = SCR_W * SCR_H;

    typedef struct packed {
        logic        written;
        logic [15:0] addr;
        logic [31:0] value;
        logic        done;
    } t_blit_result;

    typedef struct {
        bit           is_cfg;
        t_cfg_idx     idx;
        logic [10:0]  data;
        logic [31:0]  pix;
        logic         is_last;
        bit           typed;
        t_blit_result want;
    } t_stim_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [31:0]           i_src_pixel;
    logic                  i_last;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic                  o_written;
    logic [15:0]           o_fb_address;
    logic [31:0]           o_stored_value;
    logic                  o_done_res;

    // shadow of the blitter state
    logic [31:0]       fb_model [0:FB_DEPTH-1];
    logic signed [10:0] org_x;
    logic signed [8:0]  org_y;
    logic [8:0]        spr_w;
    logic              blend_on;
    logic [8:0]        col_cnt;
    logic [8:0]        row_cnt;

    t_blit_result expected_blits [$];
    t_blit_result head;
    t_stim_row    dir_rows [$];
    int           mismatch_count = 0;
    int           items_sent = 0;
    bit           stall_enable = 1'b1;

    sprite_blit_color_key_xor_core u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_src_pixel    (i_src_pixel),
        .i_last         (i_last),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_written      (o_written),
        .o_fb_address   (o_fb_address),
        .o_stored_value (o_stored_value),
        .o_done_res     (o_done_res)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #(4 * 600_000);
        $display("** sprite_blit_color_key_xor_core: FAILED **");
        $finish;
    end

    function automatic t_blit_result blit_pixel(input logic [31:0] pix, input logic is_last);
        t_blit_result r;
        int x;
        int y;
        int a;
        int nc;
        logic [31:0] val;
        logic [31:0] old_px;
        r = '0;
        r.done = is_last;
        val = pix;
        x = int'(org_x) + int'(col_cnt);
        y = int'(org_y) + int'(row_cnt);
        if (val[7:0] != 8'h00 && x >= 0 && x < SCR_W && y >= 0 && y < SCR_H) begin
            a = y * SCR_W + x;
            old_px = fb_model[a];
            if (blend_on && old_px != BG_PIXEL)
                val = val ^ old_px;
            fb_model[a] = val;
            r.written = 1'b1;
            r.addr = a[15:0];
            r.value = val;
        end
        if (is_last) begin
            col_cnt = '0;
            row_cnt = '0;
        end else begin
            nc = int'(col_cnt) + 1;
            // width 0 wraps every pixel, same as width 1
            if (nc >= int'(spr_w)) begin
                col_cnt = '0;
                row_cnt = row_cnt + 9'd1;
            end else begin
                col_cnt = nc[8:0];
            end
        end
        return r;
    endfunction

    function automatic logic [31:0] rand_pixel();
        logic [31:0] p;
        p = $urandom;
        case ($urandom_range(0, 15))
            0, 1: p[7:0] = 8'h00;
            2: p = BG_PIXEL;
            3: p = 32'hFFFF_FFFF;
            default: ;
        endcase
        return p;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    endtask

    task automatic add_item(input logic [31:0] pix, input logic is_last, input bit typed,
                            input logic wr, input logic [15:0] addr, input logic [31:0] val);
        t_stim_row r;
        r.is_cfg = 1'b0;
        r.idx = CFG_ORIGIN_X;
        r.data = '0;
        r.pix = pix;
        r.is_last = is_last;
        r.typed = typed;
        r.want.written = wr;
        r.want.addr = addr;
        r.want.value = val;
        r.want.done = is_last;
        dir_rows.push_back(r);
    endtask

    task automatic add_cfg(input t_cfg_idx idx, input logic [10:0] data);
        t_stim_row r;
        r.is_cfg = 1'b1;
        r.idx = idx;
        r.data = data;
        r.pix = '0;
        r.is_last = 1'b0;
        r.typed = 1'b0;
        r.want = '0;
        dir_rows.push_back(r);
    endtask

    // leaves the write enable high; the caller lowers it after the group
    task automatic cfg_write(input t_cfg_idx idx, input logic [10:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_ORIGIN_X:     org_x = data;
            CFG_ORIGIN_Y:     org_y = data[8:0];
            CFG_SPRITE_WIDTH: spr_w = data[8:0];
            CFG_BLEND_ENABLE: blend_on = data[0];
            default: ;
        endcase
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_blits.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic send_item(input logic [31:0] pix, input logic is_last, input bit typed,
                             input t_blit_result want);
        t_blit_result pred;
        if (stall_enable && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_src_pixel <= pix;
        i_last <= is_last;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        pred = blit_pixel(pix, is_last);
        expected_blits.push_back(typed ? want : pred);
        items_sent++;
    endtask

    task automatic run_phase(input bit wide);
        int t;
        int w_eff;
        int len;
        int kind;
        logic [10:0] ox;
        logic [8:0] oy;
        logic [8:0] w;
        logic lst;
        case ($urandom_range(0, 9))
            0: ox = $urandom_range(0, 1) ? 11'h400 : 11'h3FF;
            1: ox = 11'($urandom);
            2, 3: begin
                t = int'($urandom_range(0, 339)) - 10;
                ox = t[10:0];
            end
            default: begin
                t = int'($urandom_range(0, 48)) - 8;
                ox = t[10:0];
            end
        endcase
        case ($urandom_range(0, 9))
            0: oy = $urandom_range(0, 1) ? 9'h100 : 9'h0FF;
            1: oy = 9'($urandom);
            2, 3: begin
                t = int'($urandom_range(0, 219)) - 10;
                oy = t[8:0];
            end
            default: begin
                t = int'($urandom_range(0, 24)) - 4;
                oy = t[8:0];
            end
        endcase
        case ($urandom_range(0, 19))
            0: w = 9'd0;
            1: w = $urandom_range(0, 1) ? 9'd320 : 9'd511;
            2: w = 9'($urandom);
            default: w = 9'($urandom_range(1, 24));
        endcase
        if (wide)
            w = 9'($urandom_range(321, 400));
        drain();
        cfg_write(CFG_ORIGIN_X, ox);
        cfg_write(CFG_ORIGIN_Y, {2'b00, oy});
        cfg_write(CFG_SPRITE_WIDTH, {2'b00, w});
        cfg_write(CFG_BLEND_ENABLE, 11'($urandom_range(0, 1)));
        i_cfg_we <= 1'b0;
        w_eff = (w == 9'd0) ? 1 : int'(w);
        repeat ($urandom_range(1, 3)) begin
            if (wide)
                len = w_eff + int'($urandom_range(1, 4));
            else if (w_eff > 40)
                len = $urandom_range(1, 30);
            else
                len = w_eff * int'($urandom_range(1, 6));
            // mostly whole sprites; some never end, some end at random spots
            kind = $urandom_range(0, 9);
            for (int i = 0; i < len; i++) begin
                lst = (i == len - 1) && kind != 1;
                if (kind == 2 && $urandom_range(0, 3) == 0)
                    lst = 1'b1;
                send_item(rand_pixel(), lst, 1'b0, '0);
            end
        end
    endtask

    // enough rows that the row counter wraps back onto the screen
    task automatic run_tall_sprite();
        drain();
        cfg_write(CFG_ORIGIN_X, 11'($urandom_range(0, 319)));
        cfg_write(CFG_ORIGIN_Y, 11'($urandom_range(0, 5)));
        cfg_write(CFG_SPRITE_WIDTH, $urandom_range(0, 1) ? 11'd0 : 11'd1);
        cfg_write(CFG_BLEND_ENABLE, 11'($urandom_range(0, 1)));
        i_cfg_we <= 1'b0;
        for (int i = 0; i <= 520; i++)
            send_item(rand_pixel(), i == 520, 1'b0, '0);
    endtask

    initial begin
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (stall_enable && $urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_blits.size() == 0) begin
                report_mismatch("unexpected item", o_stored_value, '0);
            end else begin
                head = expected_blits.pop_front();
                if (o_written !== head.written)
                    report_mismatch("written", 32'(o_written), 32'(head.written));
                if (o_fb_address !== head.addr)
                    report_mismatch("fb_address", 32'(o_fb_address), 32'(head.addr));
                if (o_stored_value !== head.value)
                    report_mismatch("stored_value", o_stored_value, head.value);
                if (o_done_res !== head.done)
                    report_mismatch("done_res", 32'(o_done_res), 32'(head.done));
            end
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= CFG_ORIGIN_X;
        i_cfg_data <= '0;
        i_in_valid <= 1'b0;
        i_src_pixel <= '0;
        i_last <= 1'b0;
        foreach (fb_model[i])
            fb_model[i] = BG_PIXEL;
        org_x = '0;
        org_y = '0;
        spr_w = SPRITE_WIDTH_RST;
        blend_on = 1'b0;
        col_cnt = '0;
        row_cnt = '0;

        // reset settings: origin 0,0, width 16, overwrite
        add_item(32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, 16'd0, 32'hFFFF_FFFF);
        add_item(32'hFFFF_FF00, 1'b0, 1'b1, 1'b0, 16'd0, 32'h0);
        add_item(32'h0000_0001, 1'b0, 1'b1, 1'b1, 16'd2, 32'h0000_0001);
        add_item(32'h0000_0000, 1'b1, 1'b1, 1'b0, 16'd0, 32'h0);
        // blend over a written pixel and over background
        add_cfg(CFG_BLEND_ENABLE, 11'd1);
        add_item(32'h0F0F_0F0F, 1'b0, 1'b1, 1'b1, 16'd0, 32'hF0F0_F0F0);
        add_item(32'h0000_00FF, 1'b1, 1'b1, 1'b1, 16'd1, 32'h0000_00FF);
        add_item(32'h1234_5601, 1'b1, 1'b0, 1'b0, 16'd0, 32'h0);
        // zero width steps one row per pixel
        add_cfg(CFG_SPRITE_WIDTH, 11'd0);
        add_item(32'hA5A5_A5A5, 1'b0, 1'b0, 1'b0, 16'd0, 32'h0);
        add_item(32'h5A5A_5A01, 1'b0, 1'b0, 1'b0, 16'd0, 32'h0);
        add_item(32'h8000_0080, 1'b1, 1'b0, 1'b0, 16'd0, 32'h0);
        // most negative and most positive origins clip everything
        add_cfg(CFG_ORIGIN_X, 11'h400);
        add_cfg(CFG_ORIGIN_Y, 11'h100);
        add_item(32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, 16'd0, 32'h0);
        add_item(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 16'd0, 32'h0);
        add_cfg(CFG_ORIGIN_X, 11'h3FF);
        add_cfg(CFG_ORIGIN_Y, 11'h0FF);
        add_item(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 16'd0, 32'h0);
        // left edge one column off screen
        add_cfg(CFG_ORIGIN_X, 11'h7FF);
        add_cfg(CFG_ORIGIN_Y, 11'd0);
        add_cfg(CFG_SPRITE_WIDTH, 11'd3);
        add_cfg(CFG_BLEND_ENABLE, 11'd0);
        add_item(32'h1111_1111, 1'b0, 1'b0, 1'b0, 16'd0, 32'h0);
        add_item(32'h2222_2222, 1'b0, 1'b0, 1'b0, 16'd0, 32'h0);
        add_item(32'h3333_3333, 1'b1, 1'b0, 1'b0, 16'd0, 32'h0);
        // bottom right corner, then past the right and bottom edges
        add_cfg(CFG_ORIGIN_X, 11'd319);
        add_cfg(CFG_ORIGIN_Y, 11'd199);
        add_cfg(CFG_SPRITE_WIDTH, 11'd2);
        add_item(32'hAAAA_AAAA, 1'b0, 1'b1, 1'b1, 16'd63999, 32'hAAAA_AAAA);
        add_item(32'h5555_5555, 1'b1, 1'b1, 1'b0, 16'd0, 32'h0);
        add_cfg(CFG_SPRITE_WIDTH, 11'd1);
        add_item(32'h0000_00C3, 1'b0, 1'b1, 1'b1, 16'd63999, 32'h0000_00C3);
        add_item(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 16'd0, 32'h0);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k]) begin
            if (dir_rows[k].is_cfg) begin
                drain();
                cfg_write(dir_rows[k].idx, dir_rows[k].data);
            end else begin
                i_cfg_we <= 1'b0;
                send_item(dir_rows[k].pix, dir_rows[k].is_last, dir_rows[k].typed,
                          dir_rows[k].want);
            end
        end

        run_phase(1'b1);
        while (items_sent < 700)
            run_phase(1'b0);
        run_tall_sprite();
        while (items_sent < 1250)
            run_phase(1'b0);
        // closing stretch at full rate on both sides
        stall_enable = 1'b0;
        while (items_sent < 1400)
            run_phase(1'b0);

        drain();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && expected_blits.size() == 0)
            $display("** sprite_blit_color_key_xor_core: PASSED **");
        else
            $display("** sprite_blit_color_key_xor_core: FAILED **");
        $finish;
    end

endmodule
